// ===== hdl/tdcb_pkg.sv =====
// Shared types, constants and the sequencer program for the control TD chain builder.
package tdcb_pkg;

   typedef struct packed {
      logic [6:0]  device_address;
      logic [7:0]  request_kind;
      logic [7:0]  request_code;
      logic [15:0] request_value;
      logic [15:0] request_index;
      logic [15:0] data_length;
      logic        direction_in;
      logic [6:0]  max_packet;
      logic        slow_device;
   } req_type;

   typedef struct packed {
      logic        rejected;
      logic [2:0]  td_position;
      logic [31:0] token_word;
      logic [31:0] status_word;
      logic [63:0] setup_packet;
      logic [8:0]  data_offset;
      logic        has_buffer;
      logic        last_result;
   } rsp_type;

   localparam logic [7:0]  PID_SETUP   = 8'h2D;
   localparam logic [7:0]  PID_IN      = 8'h69;
   localparam logic [7:0]  PID_OUT     = 8'hE1;
   localparam logic [10:0] LEN_NULL    = 11'h7FF;
   localparam logic [10:0] LEN_SETUP   = 11'd7;
   localparam logic [31:0] ST_ERRCNT3  = 32'h1800_0000;
   localparam logic [31:0] ST_ACTIVE   = 32'h0080_0000;
   localparam logic [31:0] ST_LOWSPEED = 32'h0400_0000;
   localparam logic [31:0] ST_IOC      = 32'h0100_0000;
   localparam int          MAX_CHAIN   = 8;

   // Descriptor kinds a control word can emit.
   localparam logic [1:0] KIND_REJECT = 2'd0;
   localparam logic [1:0] KIND_SETUP  = 2'd1;
   localparam logic [1:0] KIND_DATA   = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   // Emission modes.
   localparam logic [1:0] EMIT_NEVER   = 2'd0;
   localparam logic [1:0] EMIT_ALWAYS  = 2'd1;
   localparam logic [1:0] EMIT_IF_COND = 2'd2;

   // Jump conditions.
   localparam logic [1:0] COND_NEVER     = 2'd0;
   localparam logic [1:0] COND_TOO_LONG  = 2'd1;
   localparam logic [1:0] COND_DATA_MORE = 2'd2;

   // Program steps.
   localparam logic [2:0] STEP_CHECK  = 3'd0;
   localparam logic [2:0] STEP_SETUP  = 3'd1;
   localparam logic [2:0] STEP_DATA   = 3'd2;
   localparam logic [2:0] STEP_STATUS = 3'd3;
   localparam logic [2:0] STEP_REJECT = 3'd4;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] emit_mode;
      logic [1:0] cond;
      logic [2:0] target;
      logic       done;
   } seq_word_type;

   typedef struct packed {
      logic       load;
      logic       emit;
      logic [1:0] kind;
   } ctl_type;

   typedef struct packed {
      logic too_long;
      logic data_more;
   } flags_type;

   function automatic seq_word_type seq_rom(input logic [2:0] step);
      seq_word_type w;
      begin
         unique case (step)
            STEP_CHECK:  w = '{KIND_REJECT, EMIT_NEVER,   COND_TOO_LONG,  STEP_REJECT, 1'b0};
            STEP_SETUP:  w = '{KIND_SETUP,  EMIT_ALWAYS,  COND_NEVER,     STEP_CHECK,  1'b0};
            STEP_DATA:   w = '{KIND_DATA,   EMIT_IF_COND, COND_DATA_MORE, STEP_DATA,   1'b0};
            STEP_STATUS: w = '{KIND_STATUS, EMIT_ALWAYS,  COND_NEVER,     STEP_CHECK,  1'b1};
            STEP_REJECT: w = '{KIND_REJECT, EMIT_ALWAYS,  COND_NEVER,     STEP_CHECK,  1'b1};
            default:     w = '{KIND_REJECT, EMIT_NEVER,   COND_NEVER,     STEP_CHECK,  1'b1};
         endcase
         return w;
      end
   endfunction

endpackage

// ===== hdl/tdcb_sequencer.sv =====
// Step counter and control-word decode for the TD chain builder.
module tdcb_sequencer
   import tdcb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  flags_type flags,
   output logic      busy,
   output ctl_type   ctl
);

   logic         active_ff, active_in;
   logic [2:0]   step_ff, step_in;
   seq_word_type word;
   logic         cond_true;
   logic         accept;

   assign accept = start && !active_ff;
   assign word   = seq_rom(step_ff);
   assign busy   = active_ff;

   always_comb begin
      unique case (word.cond)
         COND_NEVER:     cond_true = 1'b0;
         COND_TOO_LONG:  cond_true = flags.too_long;
         COND_DATA_MORE: cond_true = flags.data_more;
         default:        cond_true = 1'b0;
      endcase
   end

   always_comb begin
      ctl.load = accept;
      ctl.kind = word.kind;
      unique case (word.emit_mode)
         EMIT_ALWAYS:  ctl.emit = active_ff;
         EMIT_IF_COND: ctl.emit = active_ff && cond_true;
         default:      ctl.emit = 1'b0;
      endcase
   end

   always_comb begin
      active_in = active_ff;
      step_in   = step_ff;
      if (accept) begin
         active_in = 1'b1;
         step_in   = STEP_CHECK;
      end else if (active_ff) begin
         if (word.done) begin
            active_in = 1'b0;
         end
         step_in = cond_true ? word.target : step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff   <= STEP_CHECK;
      end else begin
         active_ff <= active_in;
         step_ff   <= step_in;
      end
   end

endmodule

// ===== hdl/tdcb_datapath.sv =====
// Request registers, packet split arithmetic and the result register.
module tdcb_datapath
   import tdcb_pkg::*;
#(
   parameter int TD_SLOTS     = 8,
   parameter int BUFFER_BYTES = 64
) (
   input  logic      clock,
   input  logic      reset,
   input  req_type   req_item,
   input  ctl_type   ctl,
   output flags_type flags,
   output logic      rsp_strobe,
   output rsp_type   rsp_item
);

   localparam logic [15:0] LIMIT = 16'(BUFFER_BYTES * (TD_SLOTS - 2));
   localparam logic [2:0]  SLOT_LAST = 3'(((TD_SLOTS < MAX_CHAIN) ? TD_SLOTS : MAX_CHAIN) - 1);

   req_type     req_ff;
   logic [15:0] remaining_ff, remaining_in;
   logic [8:0]  offset_ff, offset_in;
   logic        toggle_ff, toggle_in;
   logic [2:0]  pos_ff, pos_in;
   logic        rsp_strobe_ff;
   rsp_type     rsp_ff, rsp_in;

   logic [6:0]  chunk;
   logic [10:0] data_len;
   logic [31:0] st_base;
   logic [7:0]  data_pid;
   logic [7:0]  status_pid;

   assign flags.too_long  = req_ff.data_length > LIMIT;
   assign flags.data_more = (remaining_ff != 16'd0) && (pos_ff < SLOT_LAST);

   // The last packet may be shorter than max packet.
   assign chunk    = (remaining_ff < {9'd0, req_ff.max_packet}) ? remaining_ff[6:0]
                                                                : req_ff.max_packet;
   assign data_len = (chunk == 7'd0) ? LEN_NULL : {4'd0, chunk - 7'd1};
   assign st_base  = ST_ERRCNT3 | ST_ACTIVE | (req_ff.slow_device ? ST_LOWSPEED : 32'd0);
   assign data_pid = req_ff.direction_in ? PID_IN : PID_OUT;
   // With no data stage the status stage is always IN.
   assign status_pid = ((req_ff.data_length == 16'd0) || !req_ff.direction_in) ? PID_IN
                                                                                 : PID_OUT;

   always_comb begin
      rsp_in       = '0;
      remaining_in = remaining_ff;
      offset_in    = offset_ff;
      toggle_in    = toggle_ff;
      pos_in       = pos_ff;
      if (ctl.load) begin
         remaining_in = req_item.data_length;
         offset_in    = 9'd0;
         toggle_in    = 1'b1;
         pos_in       = 3'd0;
      end else if (ctl.emit) begin
         rsp_in.td_position = pos_ff;
         case (ctl.kind)
            KIND_SETUP: begin
               rsp_in.token_word   = {LEN_SETUP, 1'b0, 1'b0, 4'd0,
                                      req_ff.device_address, PID_SETUP};
               rsp_in.status_word  = st_base;
               rsp_in.setup_packet = {req_ff.data_length, req_ff.request_index,
                                      req_ff.request_value, req_ff.request_code,
                                      req_ff.request_kind};
               rsp_in.has_buffer   = 1'b1;
               pos_in              = pos_ff + 3'd1;
            end
            KIND_DATA: begin
               rsp_in.token_word  = {data_len, 1'b0, toggle_ff, 4'd0,
                                     req_ff.device_address, data_pid};
               rsp_in.status_word = st_base;
               rsp_in.data_offset = offset_ff;
               rsp_in.has_buffer  = 1'b1;
               offset_in          = offset_ff + {2'd0, chunk};
               remaining_in       = remaining_ff - {9'd0, chunk};
               toggle_in          = !toggle_ff;
               pos_in             = pos_ff + 3'd1;
            end
            KIND_STATUS: begin
               rsp_in.token_word  = {LEN_NULL, 1'b0, 1'b1, 4'd0,
                                     req_ff.device_address, status_pid};
               rsp_in.status_word = st_base | ST_IOC;
               rsp_in.last_result = 1'b1;
            end
            default: begin
               rsp_in.td_position = 3'd0;
               rsp_in.rejected    = 1'b1;
               rsp_in.last_result = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_item;
      end
      remaining_ff <= remaining_in;
      offset_ff    <= offset_in;
      toggle_ff    <= toggle_in;
      pos_ff       <= pos_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl.emit && !ctl.load;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== hdl/usb_control_td_chain_builder_unit.sv =====
// Top level of the USB control-transfer UHCI descriptor chain builder.
//
//   channel   ports                         beat taken when
//   request   start, busy, req_item         start high and busy low at a rising edge
//   result    rsp_strobe, rsp_item          rsp_strobe high (one cycle, no back-pressure)
//
// The microcode sequencer runs one step per clock: a check step, the SETUP
// descriptor, one step per data descriptor plus one step that ends the data
// loop, then the status descriptor. A request has D data descriptors, at most
// min(TD_SLOTS, 8) - 2; a rejected request runs the check and reject steps. Each
// result is registered and appears in the cycle after its step. Synchronous reset
// clears the sequencer and the strobe. The result side never stalls the block.
module usb_control_td_chain_builder_unit
   import tdcb_pkg::*;
#(
   parameter int TD_SLOTS     = 8,
   parameter int BUFFER_BYTES = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   ctl_type   ctl;
   flags_type flags;

   tdcb_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .busy  (busy),
      .ctl   (ctl)
   );

   tdcb_datapath #(
      .TD_SLOTS     (TD_SLOTS),
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .ctl        (ctl),
      .flags      (flags),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // A rejection is always the only and final beat of its request.
   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.rejected |-> rsp_item.last_result)
      else $error("rejected beat without last_result");

   // A beat that is not last means the sequencer is still running the chain.
   a_chain_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last_result |-> busy)
      else $error("chain beat with sequencer idle");

   // The check step never emits, so no beat follows right after a request starts.
   a_check_silent: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |=> !rsp_strobe)
      else $error("beat emitted by the check step");

   // Only data descriptors carry an offset.
   a_offset_data: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.has_buffer |-> rsp_item.data_offset == 9'd0)
      else $error("offset on a descriptor without buffer");

endmodule

// ===== bench/td_chain_checker.sv =====
// Checker for the control TD chain builder: predicts each descriptor chain and compares results.
module td_chain_checker
   import tdcb_pkg::*;
#(
   parameter int TD_SLOTS     = 8,
   parameter int BUFFER_BYTES = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_strobe,
   input  rsp_type rsp_item,
   output int      pending_descriptors,
   output int      mismatch_count
);

   localparam int unsigned REJECT_LIMIT = BUFFER_BYTES * (TD_SLOTS - 2);
   localparam int unsigned CHAIN_SLOTS  = (TD_SLOTS < MAX_CHAIN) ? TD_SLOTS : MAX_CHAIN;

   rsp_type expected_descriptors[$];

   function automatic logic [31:0] td_token(input logic [7:0] pid, input logic [6:0] addr,
                                            input logic toggle, input logic [10:0] len_code);
      // Endpoint is always 0 and bit 20 is reserved.
      return {len_code, 1'b0, toggle, 4'b0000, addr, pid};
   endfunction

   function automatic void predict_td_chain(input req_type r);
      rsp_type     d;
      logic [31:0] status_bits;
      int unsigned remaining;
      int unsigned chunk;
      int unsigned offset;
      int unsigned count;
      logic        toggle;
      logic [7:0]  pid;
      logic [10:0] len_code;
      if (32'(r.data_length) > REJECT_LIMIT) begin
         d = '0;
         d.rejected    = 1'b1;
         d.last_result = 1'b1;
         expected_descriptors.push_back(d);
      end else begin
         status_bits = ST_ERRCNT3 | ST_ACTIVE | (r.slow_device ? ST_LOWSPEED : 32'h0);

         d = '0;
         d.token_word   = td_token(PID_SETUP, r.device_address, 1'b0, LEN_SETUP);
         d.status_word  = status_bits;
         d.setup_packet = {r.data_length, r.request_index, r.request_value,
                           r.request_code, r.request_kind};
         d.has_buffer   = 1'b1;
         expected_descriptors.push_back(d);

         count     = 1;
         remaining = 32'(r.data_length);
         offset    = 0;
         toggle    = 1'b1;
         // With a zero max packet the loop only stops when the slots run out.
         while (remaining > 0 && count < CHAIN_SLOTS - 1) begin
            chunk    = (remaining < 32'(r.max_packet)) ? remaining : 32'(r.max_packet);
            len_code = (chunk == 0) ? LEN_NULL : 11'(chunk - 1);
            pid      = r.direction_in ? PID_IN : PID_OUT;
            d = '0;
            d.td_position = 3'(count);
            d.token_word  = td_token(pid, r.device_address, toggle, len_code);
            d.status_word = status_bits;
            d.data_offset = 9'(offset);
            d.has_buffer  = 1'b1;
            expected_descriptors.push_back(d);
            offset    += chunk;
            remaining -= chunk;
            toggle    = ~toggle;
            count++;
         end

         pid = (r.data_length == 16'd0 || !r.direction_in) ? PID_IN : PID_OUT;
         d = '0;
         d.td_position = 3'(count);
         d.token_word  = td_token(pid, r.device_address, 1'b1, LEN_NULL);
         d.status_word = status_bits | ST_IOC;
         d.last_result = 1'b1;
         expected_descriptors.push_back(d);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) report_mismatch(what, want, got);
   endtask

   initial mismatch_count = 0;

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         expected_descriptors.delete();
         pending_descriptors <= 0;
      end else begin
         // Compare before predicting: a request accepted at this edge cannot
         // have a result on the same edge.
         if (rsp_strobe) begin
            if (expected_descriptors.size() == 0) begin
               report_mismatch("result beat with nothing expected, token", 64'h0,
                               64'(rsp_item.token_word));
            end else begin
               want = expected_descriptors.pop_front();
               check_field("rejected", 64'(want.rejected), 64'(rsp_item.rejected));
               check_field("td_position", 64'(want.td_position),
                           64'(rsp_item.td_position));
               check_field("token_word", 64'(want.token_word), 64'(rsp_item.token_word));
               check_field("status_word", 64'(want.status_word),
                           64'(rsp_item.status_word));
               check_field("setup_packet", want.setup_packet, rsp_item.setup_packet);
               check_field("data_offset", 64'(want.data_offset),
                           64'(rsp_item.data_offset));
               check_field("has_buffer", 64'(want.has_buffer), 64'(rsp_item.has_buffer));
               check_field("last_result", 64'(want.last_result),
                           64'(rsp_item.last_result));
            end
         end
         if (start && !busy) predict_td_chain(req_item);
         pending_descriptors <= expected_descriptors.size();
      end
   end

endmodule

// ===== bench/tb_usb_control_td_chain_builder_unit.sv =====
// Testbench top for the control TD chain builder: request stimulus, watchdog and verdict.
module tb_usb_control_td_chain_builder_unit
   import tdcb_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_REQUESTS = 500;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;
   int      pending_descriptors;
   int      mismatch_count;
   bit      idle_on  = 1'b1;

   always #2 clock = ~clock;

   usb_control_td_chain_builder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   td_chain_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_item            (req_item),
      .rsp_strobe          (rsp_strobe),
      .rsp_item            (rsp_item),
      .pending_descriptors (pending_descriptors),
      .mismatch_count      (mismatch_count)
   );

   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      r.device_address = 7'($urandom_range(127));
      r.request_kind   = 8'($urandom_range(255));
      r.request_code   = 8'($urandom_range(255));
      r.request_value  = 16'($urandom_range(65535));
      r.request_index  = 16'($urandom_range(65535));
      r.direction_in   = 1'($urandom_range(1));
      r.slow_device    = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 15)      r.data_length = 16'd0;
      else if (pick < 75) r.data_length = 16'($urandom_range(384));
      else if (pick < 87) r.data_length = 16'($urandom_range(390, 378));
      else                r.data_length = 16'($urandom_range(65535, 385));
      pick = $urandom_range(99);
      if (pick < 5)       r.max_packet = 7'd0;
      else if (pick < 15) r.max_packet = 7'($urandom_range(127, 65));
      else if (pick < 40) r.max_packet = 7'(8 << $urandom_range(3));
      else                r.max_packet = 7'($urandom_range(64, 1));
      return r;
   endfunction

   // Leaves start high after the accepting edge so back-to-back beats need
   // no second assignment in the same step.
   task automatic send_request(input req_type r);
      while (idle_on && $urandom_range(99) < 36) begin
         start    <= 1'b0;
         req_item <= random_request();
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_shaped(input int unsigned len, input bit dir_in,
                              input int unsigned mps, input bit ls);
      req_type r;
      r = random_request();
      r.data_length  = 16'(len);
      r.direction_in = dir_in;
      r.max_packet   = 7'(mps);
      r.slow_device  = ls;
      send_request(r);
   endtask

   // The checker's count is registered, so look only after the next edge.
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_descriptors != 0);
   endtask

   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      req_type r;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed requests: stage shapes, length and packet-size corners.
      send_shaped(0, 1'b0, 64, 1'b0);
      send_shaped(0, 1'b1, 64, 1'b1);
      send_shaped(1, 1'b1, 64, 1'b0);
      send_shaped(1, 1'b0, 64, 1'b1);
      send_shaped(64, 1'b1, 64, 1'b0);
      send_shaped(65, 1'b0, 64, 1'b0);
      send_shaped(384, 1'b1, 64, 1'b1);
      send_shaped(385, 1'b0, 64, 1'b0);
      send_shaped(65535, 1'b1, 127, 1'b1);
      send_shaped(384, 1'b0, 8, 1'b0);
      send_shaped(10, 1'b1, 0, 1'b0);
      send_shaped(0, 1'b0, 0, 1'b1);
      send_shaped(300, 1'b0, 127, 1'b0);
      send_shaped(5, 1'b1, 1, 1'b1);
      send_shaped(383, 1'b1, 1, 1'b0);
      send_shaped(128, 1'b0, 32, 1'b1);
      r = '1;
      r.data_length = 16'd384;
      send_request(r);
      r = '1;
      r.max_packet = 7'd64;
      send_request(r);
      r = '0;
      send_request(r);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         idle_on = !(n >= 200 && n < 300);
         if (n % 125 == 124) wait_for_drain();
         send_request(random_request());
      end
      wait_for_drain();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && pending_descriptors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/tdcb_pkg.sv
hdl/tdcb_sequencer.sv
hdl/tdcb_datapath.sv
hdl/usb_control_td_chain_builder_unit.sv
bench/td_chain_checker.sv
bench/tb_usb_control_td_chain_builder_unit.sv
